@@ src/ps2pa_pkg.sv @@
package ps2pa_pkg;

   // Request codes on req_type.
   localparam logic REQ_BYTE    = 1'b0;
   localparam logic REQ_CONSUME = 1'b1;

   // Reply codes on rsp_reply_kind.
   localparam logic KIND_PACKET  = 1'b0;
   localparam logic KIND_CONSUME = 1'b1;

   // Bit positions inside the first packet byte.
   localparam int SYNC_BIT_POS  = 3;
   localparam int XSIGN_BIT_POS = 4;
   localparam int YSIGN_BIT_POS = 5;

   localparam int BUTTON_BITS = 3;
   localparam int LIMIT_BITS  = 11;
   localparam int ACC_BITS    = 12;
   localparam int DX_BITS     = 9;
   localparam int DY_BITS     = 10;
   localparam int POS_OUT_BITS = 32;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELTA_LIMIT     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCUMULATE_MODE = 2'd1;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 11'd2000;
   localparam logic MODE_RESET = 1'b1;

   localparam int POSITION_BITS_DEFAULT = 32;

   // Command queue between the byte front end and the accumulator back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PHASE_FIRST,
      PHASE_SECOND,
      PHASE_THIRD
   } phase_type;

   typedef struct packed {
      logic                   kind;
      logic [BUTTON_BITS-1:0] buttons;
      logic [DX_BITS-1:0]     dx;
      logic [DY_BITS-1:0]     dy;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic                   valid;
      logic                   full;
      logic [QCOUNT_BITS-1:0] count;
   } qstat_type;

   typedef struct packed {
      logic [LIMIT_BITS-1:0] delta_limit;
      logic                  accumulate_mode;
   } cfg_type;

endpackage

@@ src/ps2pa_front.sv @@
module ps2pa_front
   import ps2pa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_type,
   input  logic [7:0] req_data_byte,
   input  qstat_type q_stat,
   output push_type  q_push
);

   phase_type  phase_ff, phase_in;
   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic       accept;
   logic [DY_BITS-1:0] dy_ext;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;

   // Next state: the phase only moves on received bytes, never on consume.
   always_comb begin
      phase_in = phase_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      if (accept && (req_type == REQ_BYTE)) begin
         unique case (phase_ff)
            PHASE_FIRST: begin
               if (req_data_byte[SYNC_BIT_POS]) begin
                  held0_in = req_data_byte;
                  phase_in = PHASE_SECOND;
               end
            end
            PHASE_SECOND: begin
               held1_in = req_data_byte;
               phase_in = PHASE_THIRD;
            end
            PHASE_THIRD: begin
               phase_in = PHASE_FIRST;
            end
            default: begin
               phase_in = PHASE_FIRST;
            end
         endcase
      end
   end

   assign dy_ext = {held0_ff[YSIGN_BIT_POS], held0_ff[YSIGN_BIT_POS], req_data_byte};

   // Outputs: a consume request or a finished packet becomes one command.
   always_comb begin
      q_push.push        = 1'b0;
      q_push.cmd.kind    = KIND_CONSUME;
      q_push.cmd.buttons = '0;
      q_push.cmd.dx      = '0;
      q_push.cmd.dy      = '0;
      if (accept) begin
         if (req_type == REQ_CONSUME) begin
            q_push.push = 1'b1;
         end else if (phase_ff == PHASE_THIRD) begin
            q_push.push        = 1'b1;
            q_push.cmd.kind    = KIND_PACKET;
            q_push.cmd.buttons = held0_ff[BUTTON_BITS-1:0];
            q_push.cmd.dx      = {held0_ff[XSIGN_BIT_POS], held1_ff};
            q_push.cmd.dy      = DY_BITS'(-dy_ext);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

endmodule

@@ src/ps2pa_queue.sv @@
module ps2pa_queue
   import ps2pa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  q_push,
   input  logic      pop,
   output qstat_type q_stat,
   output cmd_type   head
);

   localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PtrBits-1:0] LastSlot = PtrBits'(QUEUE_DEPTH - 1);
   localparam logic [QCOUNT_BITS-1:0] FullCount = QCOUNT_BITS'(QUEUE_DEPTH);

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign do_push = q_push.push && (count_ff != FullCount);
   assign do_pop  = pop && (count_ff != '0);

   assign q_stat.valid = (count_ff != '0);
   assign q_stat.full  = (count_ff == FullCount);
   assign q_stat.count = count_ff;
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCOUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCOUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

endmodule

@@ src/ps2pa_back.sv @@
module ps2pa_back
   import ps2pa_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          q_valid,
   input  cmd_type                       head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_reply_kind,
   output logic [BUTTON_BITS-1:0]        rsp_buttons,
   output logic signed [DX_BITS-1:0]     rsp_packet_dx,
   output logic signed [DY_BITS-1:0]     rsp_packet_dy,
   output logic signed [ACC_BITS-1:0]    rsp_acc_dx_out,
   output logic signed [ACC_BITS-1:0]    rsp_acc_dy_out,
   output logic signed [POS_OUT_BITS-1:0] rsp_pos_x_out,
   output logic signed [POS_OUT_BITS-1:0] rsp_pos_y_out
);

   localparam int SumBits = ACC_BITS + 1;

   logic [ACC_BITS-1:0]      acc_dx_ff, acc_dx_in;
   logic [ACC_BITS-1:0]      acc_dy_ff, acc_dy_in;
   logic [POSITION_BITS-1:0] pos_x_ff, pos_x_in;
   logic [POSITION_BITS-1:0] pos_y_ff, pos_y_in;
   logic [BUTTON_BITS-1:0]   last_buttons_ff, last_buttons_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                          rsp_kind_ff;
   logic [BUTTON_BITS-1:0]        rsp_buttons_ff;
   logic [DX_BITS-1:0]            rsp_dx_ff;
   logic [DY_BITS-1:0]            rsp_dy_ff;
   logic [ACC_BITS-1:0]           rsp_acc_dx_ff, rsp_acc_dy_ff;
   logic [POS_OUT_BITS-1:0]       rsp_pos_x_ff, rsp_pos_y_ff;

   logic signed [SumBits-1:0] acc_x_ext, acc_y_ext, dx_ext, dy_ext;
   logic signed [SumBits-1:0] sum_x, sum_y, lim_pos;
   logic [ACC_BITS-1:0]       clamp_x, clamp_y;

   function automatic logic [ACC_BITS-1:0] clamp_sum(
      input logic signed [SumBits-1:0] v,
      input logic signed [SumBits-1:0] lim
   );
      logic signed [SumBits-1:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r[ACC_BITS-1:0];
   endfunction

   assign pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   assign acc_x_ext = {acc_dx_ff[ACC_BITS-1], acc_dx_ff};
   assign acc_y_ext = {acc_dy_ff[ACC_BITS-1], acc_dy_ff};
   assign dx_ext    = {{(SumBits-DX_BITS){head.dx[DX_BITS-1]}}, head.dx};
   assign dy_ext    = {{(SumBits-DY_BITS){head.dy[DY_BITS-1]}}, head.dy};
   assign lim_pos   = {{(SumBits-LIMIT_BITS){1'b0}}, cfg.delta_limit};
   assign sum_x     = acc_x_ext + dx_ext;
   assign sum_y     = acc_y_ext + dy_ext;
   assign clamp_x   = clamp_sum(sum_x, lim_pos);
   assign clamp_y   = clamp_sum(sum_y, lim_pos);

   always_comb begin
      acc_dx_in       = acc_dx_ff;
      acc_dy_in       = acc_dy_ff;
      pos_x_in        = pos_x_ff;
      pos_y_in        = pos_y_ff;
      last_buttons_in = last_buttons_ff;
      if (pop) begin
         if (head.kind == KIND_CONSUME) begin
            acc_dx_in = '0;
            acc_dy_in = '0;
         end else begin
            if (cfg.accumulate_mode) begin
               acc_dx_in = clamp_x;
               acc_dy_in = clamp_y;
            end else begin
               acc_dx_in = dx_ext[ACC_BITS-1:0];
               acc_dy_in = dy_ext[ACC_BITS-1:0];
            end
            pos_x_in        = pos_x_ff + POSITION_BITS'($signed(head.dx));
            pos_y_in        = pos_y_ff + POSITION_BITS'($signed(head.dy));
            last_buttons_in = head.buttons;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_dx_ff       <= '0;
         acc_dy_ff       <= '0;
         pos_x_ff        <= '0;
         pos_y_ff        <= '0;
         last_buttons_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         acc_dx_ff       <= acc_dx_in;
         acc_dy_ff       <= acc_dy_in;
         pos_x_ff        <= pos_x_in;
         pos_y_ff        <= pos_y_in;
         last_buttons_ff <= last_buttons_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // A consume reply reports the values held before clearing.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_kind_ff <= head.kind;
         if (head.kind == KIND_CONSUME) begin
            rsp_buttons_ff <= last_buttons_ff;
            rsp_dx_ff      <= '0;
            rsp_dy_ff      <= '0;
            rsp_acc_dx_ff  <= acc_dx_ff;
            rsp_acc_dy_ff  <= acc_dy_ff;
         end else begin
            rsp_buttons_ff <= head.buttons;
            rsp_dx_ff      <= head.dx;
            rsp_dy_ff      <= head.dy;
            rsp_acc_dx_ff  <= acc_dx_in;
            rsp_acc_dy_ff  <= acc_dy_in;
         end
         rsp_pos_x_ff <= POS_OUT_BITS'($signed(pos_x_in));
         rsp_pos_y_ff <= POS_OUT_BITS'($signed(pos_y_in));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_kind = rsp_kind_ff;
   assign rsp_buttons    = rsp_buttons_ff;
   assign rsp_packet_dx  = rsp_dx_ff;
   assign rsp_packet_dy  = rsp_dy_ff;
   assign rsp_acc_dx_out = rsp_acc_dx_ff;
   assign rsp_acc_dy_out = rsp_acc_dy_ff;
   assign rsp_pos_x_out  = rsp_pos_x_ff;
   assign rsp_pos_y_out  = rsp_pos_y_ff;

endmodule

@@ src/ps2pa_core_top.sv @@
// PS/2 mouse packet assembler.
// The request channel (req_valid / req_stall) carries either one byte
// received from the mouse or a consume request. A request is taken at any
// clock edge where req_valid is high and req_stall is low.
// Bytes are gathered into three-byte packets; a first byte without its sync
// bit is dropped. The third byte of a packet and every consume request each
// produce exactly one reply on the response channel (rsp_valid / rsp_stall).
// One request is accepted per cycle while req_stall is low. A reply passes
// through the command queue that follows the byte front end and then the
// output register of the accumulator stage.
// When the receiver stalls, the reply holds in the output register, the
// two-entry queue fills behind it, and req_stall rises once it is full.
// The configuration channel (csr_valid / csr_ready) is always ready and
// writes the delta limit (index 0) or the accumulate mode (index 1).
// Synchronous reset returns the packet phase to the first byte, clears the
// accumulators, the position and the last buttons, empties the queue, and
// restores a limit of 2000 with accumulate mode on.
module ps2_mouse_packet_assembler_core
   import ps2pa_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_type,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_reply_kind,
   output logic [BUTTON_BITS-1:0]         rsp_buttons,
   output logic signed [DX_BITS-1:0]      rsp_packet_dx,
   output logic signed [DY_BITS-1:0]      rsp_packet_dy,
   output logic signed [ACC_BITS-1:0]     rsp_acc_dx_out,
   output logic signed [ACC_BITS-1:0]     rsp_acc_dy_out,
   output logic signed [POS_OUT_BITS-1:0] rsp_pos_x_out,
   output logic signed [POS_OUT_BITS-1:0] rsp_pos_y_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [LIMIT_BITS-1:0]          csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   push_type  q_push;
   qstat_type q_stat;
   cmd_type   head;
   logic      pop;

   // The register file never pushes back; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DELTA_LIMIT) begin
            cfg_in.delta_limit = csr_wdata;
         end else if (csr_index == CSR_ACCUMULATE_MODE) begin
            cfg_in.accumulate_mode = csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delta_limit     <= LIMIT_RESET;
         cfg_ff.accumulate_mode <= MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: tracks the packet phase and turns requests into commands.
   ps2pa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .q_stat        (q_stat),
      .q_push        (q_push)
   );

   // Short queue that lets the front end keep taking bytes during a stall.
   ps2pa_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (pop),
      .q_stat (q_stat),
      .head   (head)
   );

   // Back end: accumulators, position and the registered reply.
   ps2pa_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_stat.valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reply_kind (rsp_reply_kind),
      .rsp_buttons    (rsp_buttons),
      .rsp_packet_dx  (rsp_packet_dx),
      .rsp_packet_dy  (rsp_packet_dy),
      .rsp_acc_dx_out (rsp_acc_dx_out),
      .rsp_acc_dy_out (rsp_acc_dy_out),
      .rsp_pos_x_out  (rsp_pos_x_out),
      .rsp_pos_y_out  (rsp_pos_y_out)
   );

`ifndef SYNTH
   // No reply may be pending in the cycle after reset.
   a_reset_clears_reply: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("reply pending right after reset");

   // The queue never holds more commands than it has slots.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCOUNT_BITS'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   // A consume reply never carries packet deltas.
   a_consume_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_kind == KIND_CONSUME) |->
      (rsp_packet_dx == '0 && rsp_packet_dy == '0))
      else $error("consume reply with nonzero packet delta");

   // The negated Y delta stays within the nine-bit range, mirrored.
   a_dy_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_kind == KIND_PACKET) |->
      (rsp_packet_dy >= -10'sd255 && rsp_packet_dy <= 10'sd256))
      else $error("packet Y delta out of range");
`endif

endmodule
